FILE: src/solc_pkg.sv
// Shared types and constants for the setup option list checker.
`default_nettype none
package solc_pkg;

	localparam int MaxOptionLengthDef = 65535;
	localparam int ByteW = 8;
	localparam int AccW = 62;
	localparam int TypeW = 64;
	localparam int VarLeftW = 3;

	typedef struct packed {
		logic             has_byte;
		logic [ByteW-1:0] data_byte;
		logic             last_byte;
	} item_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_BAD_TYPE     = 2'd1,
		ST_TRUNC_VALUE  = 2'd2,
		ST_TRUNC_LENGTH = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		PH_TYPE   = 4'b0001,
		PH_VALUE  = 4'b0010,
		PH_LENGTH = 4'b0100,
		PH_SKIP   = 4'b1000
	} phase_t;

endpackage
`default_nettype wire

FILE: src/solc_ifs.sv
// Valid/ready channel interfaces for payload bytes and status results.
`default_nettype none
interface solc_in_if;
	logic       valid;
	logic       ready;
	logic       has_byte;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output has_byte, output data_byte, output last_byte,
		input ready);
	modport sink(input valid, input has_byte, input data_byte, input last_byte,
		output ready);
endinterface

interface solc_out_if;
	logic              valid;
	logic              ready;
	solc_pkg::status_t status;

	modport source(output valid, output status, input ready);
	modport sink(input valid, input status, output ready);
endinterface
`default_nettype wire

FILE: src/solc_core.sv
// Parse state and per-byte next-state logic of the option list checker.
`default_nettype none
module solc_core #(
	parameter int MAX_OPTION_LENGTH = solc_pkg::MaxOptionLengthDef
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire solc_pkg::item_t   item,
	output solc_pkg::status_t      status
);
	import solc_pkg::*;

	localparam int SkipW = $clog2(MAX_OPTION_LENGTH + 1);
	localparam logic [AccW-1:0] MaxLen = AccW'(MAX_OPTION_LENGTH);

	phase_t                phase_q, phase_n;
	logic [AccW-1:0]       accum_q, accum_n;
	logic [VarLeftW-1:0]   vleft_q, vleft_n;
	logic [TypeW-1:0]      type_q, type_n;
	logic                  seen_q, seen_n;
	logic [SkipW-1:0]      skip_q, skip_n;
	status_t               err_q, err_n;

	logic                  take;
	logic [TypeW:0]        type_sum;

	assign take = item.has_byte && (err_q == ST_OK);
	assign type_sum = {1'b0, type_q} + {{(TypeW + 1 - AccW){1'b0}}, accum_n};

	always_comb begin
		phase_n = phase_q;
		accum_n = accum_q;
		vleft_n = vleft_q;
		type_n  = type_q;
		seen_n  = seen_q;
		skip_n  = skip_q;
		err_n   = err_q;
		if (take) begin
			if (phase_q == PH_SKIP) begin
				skip_n = skip_q - SkipW'(1);
				if (skip_n == '0)
					phase_n = PH_TYPE;
			end else begin
				if (vleft_q == '0) begin
					// first byte: two-bit prefix picks 1, 2, 4 or 8 bytes
					accum_n = {{(AccW - 6){1'b0}}, item.data_byte[5:0]};
					vleft_n = VarLeftW'((4'd1 << item.data_byte[7:6]) - 4'd1);
				end else begin
					accum_n = {accum_q[AccW-ByteW-1:0], item.data_byte};
					vleft_n = vleft_q - VarLeftW'(1);
				end
				if (vleft_n == '0) begin
					case (phase_q)
						PH_TYPE: begin
							if (seen_q && type_sum[TypeW]) begin
								err_n = ST_BAD_TYPE;
							end else begin
								type_n  = seen_q ? type_sum[TypeW-1:0]
									: {{(TypeW - AccW){1'b0}}, accum_n};
								seen_n  = 1'b1;
								phase_n = type_n[0] ? PH_LENGTH : PH_VALUE;
							end
						end
						PH_VALUE: phase_n = PH_TYPE;
						default: begin
							if (accum_n > MaxLen) begin
								err_n = ST_TRUNC_LENGTH;
							end else if (accum_n == '0) begin
								phase_n = PH_TYPE;
							end else begin
								skip_n  = accum_n[SkipW-1:0];
								phase_n = PH_SKIP;
							end
						end
					endcase
				end
			end
		end
	end

	// status as seen after this item's byte
	always_comb begin
		if (err_n != ST_OK) begin
			status = err_n;
		end else begin
			case (phase_n)
				PH_TYPE:  status = (vleft_n != '0) ? ST_BAD_TYPE : ST_OK;
				PH_VALUE: status = ST_TRUNC_VALUE;
				default:  status = ST_TRUNC_LENGTH;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			accum_q <= '0;
			vleft_q <= '0;
			type_q  <= '0;
			seen_q  <= 1'b0;
			skip_q  <= '0;
			err_q   <= ST_OK;
		end else if (advance) begin
			if (item.last_byte) begin
				// end of payload: start the next one from scratch
				phase_q <= PH_TYPE;
				accum_q <= '0;
				vleft_q <= '0;
				type_q  <= '0;
				seen_q  <= 1'b0;
				skip_q  <= '0;
				err_q   <= ST_OK;
			end else begin
				phase_q <= phase_n;
				accum_q <= accum_n;
				vleft_q <= vleft_n;
				type_q  <= type_n;
				seen_q  <= seen_n;
				skip_q  <= skip_n;
				err_q   <= err_n;
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/setup_option_list_checker_unit.sv
// Top level of the setup option list checker.
`default_nettype none
// Takes a setup-message payload one byte per transfer and checks its option
// list: varint type deltas summed with 64-bit overflow check, a varint value
// after even types, a varint length (at most MAX_OPTION_LENGTH) plus skipped
// bytes after odd types. One status comes out for the transfer that carries
// last_byte; an empty payload is a single transfer with has_byte low. An
// accepted item is held in the input register while the parse state and
// status are updated, and a last item's status enters the result register
// as that item leaves the input register. The block takes one item per clock
// cycle; only an item with last_byte waits, and only while the result
// register still holds a status that has not been taken.
module setup_option_list_checker_unit #(
	parameter int MAX_OPTION_LENGTH = solc_pkg::MaxOptionLengthDef
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	solc_in_if.sink    in_item,
	solc_out_if.source result
);
	import solc_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	logic    out_valid_q;
	status_t status_q;
	status_t step_status;
	logic    out_free;
	logic    advance;

	assign out_free = !out_valid_q || result.ready;
	assign advance = valid_s1 && (!item_s1.last_byte || out_free);
	assign in_item.ready = !valid_s1 || advance;
	assign result.valid = out_valid_q;
	assign result.status = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			item_s1  <= '0;
		end else if (in_item.valid && in_item.ready) begin
			valid_s1 <= 1'b1;
			item_s1  <= '{has_byte: in_item.has_byte, data_byte: in_item.data_byte,
				last_byte: in_item.last_byte};
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	solc_core #(
		.MAX_OPTION_LENGTH(MAX_OPTION_LENGTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.status (step_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
		end else if (advance && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
			status_q    <= step_status;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	// input side only stalls with an item in the register
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		!in_item.ready |-> valid_s1)
		else $error("input stalled with empty item register");

	// a new status only comes from a last item leaving the input register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && item_s1.last_byte))
		else $error("result raised without a last item");

	// a last item blocked by a full result register is held, not dropped
	a_last_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.last_byte && out_valid_q && !result.ready) |=> valid_s1)
		else $error("last item dropped while result register full");
`endif

endmodule
`default_nettype wire

FILE: test/setup_option_list_checker_unit_tb.sv
// Self-checking testbench for the setup option list checker unit.
`timescale 1ns / 1ps

module setup_option_list_checker_unit_tb;
	import solc_pkg::*;

	localparam int MaxLen = MaxOptionLengthDef;
	localparam int CycleLimit = 1_500_000;
	localparam int LongHold = 300;

	typedef logic [7:0] payload_q_t[$];

	// Tracks the option-list parse of each payload and keeps the statuses still owed.
	class option_list_scoreboard;
		phase_t      phase;
		logic [61:0] accum;
		logic [2:0]  varint_left;
		logic [63:0] run_type;
		bit          type_seen;
		logic [15:0] skip_left;
		status_t     err;
		status_t     expected_status_q[$];
		int          errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			phase = PH_TYPE;
			accum = '0;
			varint_left = '0;
			run_type = '0;
			type_seen = 0;
			skip_left = '0;
			err = ST_OK;
		endfunction

		function void take_byte(logic [7:0] b);
			logic [63:0] v;
			if (phase == PH_SKIP) begin
				skip_left--;
				if (skip_left == 0)
					phase = PH_TYPE;
				return;
			end
			if (varint_left == 0) begin
				accum = {56'b0, b[5:0]};
				varint_left = 3'((1 << b[7:6]) - 1);
			end else begin
				accum = {accum[53:0], b};
				varint_left--;
			end
			if (varint_left != 0)
				return;
			v = {2'b00, accum};
			case (phase)
				PH_TYPE: begin
					// overflow when the sum would not fit in 64 bits
					if (type_seen && v > ~run_type) begin
						err = ST_BAD_TYPE;
					end else begin
						run_type = type_seen ? run_type + v : v;
						type_seen = 1;
						phase = run_type[0] ? PH_LENGTH : PH_VALUE;
					end
				end
				PH_VALUE: phase = PH_TYPE;
				default: begin
					if (v > 64'(MaxLen)) begin
						err = ST_TRUNC_LENGTH;
					end else if (v == 0) begin
						phase = PH_TYPE;
					end else begin
						skip_left = v[15:0];
						phase = PH_SKIP;
					end
				end
			endcase
		endfunction

		function void note_item(logic has_byte, logic [7:0] data_byte, logic last_byte);
			status_t s;
			if (has_byte && err == ST_OK)
				take_byte(data_byte);
			if (!last_byte)
				return;
			if (err != ST_OK)
				s = err;
			else if (phase == PH_TYPE)
				s = (varint_left != 0) ? ST_BAD_TYPE : ST_OK;
			else if (phase == PH_VALUE)
				s = ST_TRUNC_VALUE;
			else
				s = ST_TRUNC_LENGTH;
			expected_status_q.push_back(s);
			clear();
		endfunction

		function void check_status(status_t got);
			status_t exp_s;
			if (expected_status_q.size() == 0) begin
				$error("status: unexpected transfer, got %0d", got);
				errors++;
				return;
			end
			exp_s = expected_status_q.pop_front();
			if (got !== exp_s) begin
				$error("status mismatch: expected %0d, got %0d", exp_s, got);
				errors++;
			end
		endfunction

		function int pending();
			return expected_status_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	bit   hold_req;
	int   n_sent;
	int   cycle_cnt;
	option_list_scoreboard sb;

	solc_in_if  in_if();
	solc_out_if out_if();

	setup_option_list_checker_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_if),
		.result(out_if)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CycleLimit) begin
			$display("FAIL setup_option_list_checker_unit");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_if.valid && out_if.ready)
			sb.check_status(out_if.status);
	end

	// Result side: short random stalls, plus one long hold-off on request.
	initial begin
		int stall_left;
		int hold_cnt;
		stall_left = 0;
		hold_cnt = 0;
		out_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_if.ready = 1'b0;
				hold_cnt++;
				if (hold_cnt == LongHold) begin
					hold_cnt = 0;
					hold_req = 0;
				end
			end else if (stall_left > 0) begin
				out_if.ready = 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_if.ready = 1'b0;
				stall_left = $urandom_range(0, 3);
			end else begin
				out_if.ready = 1'b1;
			end
		end
	end

	function automatic logic [61:0] rand_varint_value();
		case ($urandom_range(0, 3))
			0: return 62'($urandom_range(0, 63));
			1: return 62'($urandom_range(0, 16383));
			2: return 62'($urandom);
			default: return 62'({$urandom, $urandom}) >> $urandom_range(0, 30);
		endcase
	endfunction

	// Encode big-endian with the two-bit length prefix, sometimes non-minimal.
	function automatic void push_varint(ref payload_q_t p, input logic [61:0] v);
		int code;
		int n;
		logic [63:0] w;
		code = (v < 64) ? 0 : (v < 16384) ? 1 : (v < 62'h4000_0000) ? 2 : 3;
		if ($urandom_range(0, 3) == 0)
			code = $urandom_range(code, 3);
		n = 1 << code;
		w = 64'(v);
		w[8*n-1 -: 2] = 2'(code);
		for (int i = n - 1; i >= 0; i--)
			p.push_back(w[8*i +: 8]);
	endfunction

	function automatic void build_payload(output payload_q_t p, output bit tail_empty);
		int kind;
		int nopt;
		int cut;
		int len;
		int r;
		bit big;
		bit seen;
		logic [63:0] rt;
		logic [61:0] d;
		p = {};
		kind = $urandom_range(0, 99);
		if (kind >= 85) begin
			repeat ($urandom_range(1, 8))
				p.push_back(8'($urandom));
		end else begin
			// runs of near-maximum deltas push the type sum into overflow
			big = kind < 8;
			nopt = big ? $urandom_range(4, 6) : $urandom_range(0, 4);
			seen = 0;
			rt = '0;
			repeat (nopt) begin
				d = big ? 62'h3FFF_FFFF_FFFF_FFFF - 62'($urandom_range(0, 3))
					: rand_varint_value();
				rt = seen ? rt + 64'(d) : 64'(d);
				seen = 1;
				push_varint(p, d);
				if (!rt[0]) begin
					push_varint(p, rand_varint_value());
				end else begin
					r = $urandom_range(0, 49);
					if (r < 40)
						len = $urandom_range(0, 8);
					else if (r < 47)
						len = $urandom_range(9, 300);
					else if (r < 49)
						len = $urandom_range(MaxLen + 1, 1 << 20);
					else
						len = $urandom_range(301, MaxLen);
					push_varint(p, 62'(len));
					if (len <= 300)
						repeat (len)
							p.push_back(8'($urandom));
				end
			end
			if (kind >= 70 && p.size() > 0) begin
				cut = $urandom_range(0, p.size() - 1);
				while (p.size() > cut)
					void'(p.pop_back());
			end
		end
		tail_empty = (p.size() == 0) || ($urandom_range(0, 9) == 0);
	endfunction

	task automatic send_item(input logic has_byte, input logic [7:0] data_byte,
			input logic last_byte);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_if.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_if.valid = 1'b1;
		in_if.has_byte = has_byte;
		in_if.data_byte = data_byte;
		in_if.last_byte = last_byte;
		do @(posedge clk); while (!in_if.ready);
		sb.note_item(has_byte, data_byte, last_byte);
		@(negedge clk);
	endtask

	task automatic send_payload(input payload_q_t p, input bit tail_empty);
		foreach (p[i]) begin
			// drop in a byteless item now and then; it must be ignored
			if ($urandom_range(0, 24) == 0)
				send_item(1'b0, 8'($urandom), 1'b0);
			send_item(1'b1, p[i], (i == p.size() - 1) && !tail_empty);
			n_sent++;
		end
		if (tail_empty) begin
			send_item(1'b0, 8'($urandom), 1'b1);
			n_sent++;
		end
	endtask

	task automatic drain_results();
		in_if.valid = 1'b0;
		while (sb.pending() != 0 || hold_req)
			@(negedge clk);
	endtask

	initial begin
		payload_q_t p;
		bit te;
		sb = new();
		calm = 0;
		hold_req = 0;
		n_sent = 0;
		cycle_cnt = 0;
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.has_byte = 1'b0;
		in_if.data_byte = '0;
		in_if.last_byte = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty payload
		p = {};
		send_payload(p, 1);
		// even type, one-byte value
		p = {8'h00, 8'h3F};
		send_payload(p, 0);
		// type delta cut short
		p = {8'h40};
		send_payload(p, 0);
		// value varint missing
		p = {8'h02};
		send_payload(p, 0);
		// skip bytes still owed
		p = {8'h01, 8'h02, 8'hAA};
		send_payload(p, 0);
		// odd type with zero length, then a four-byte delta to another odd type
		p = {8'h01, 8'h00, 8'h80, 8'h00, 8'h00, 8'h02, 8'h00};
		send_payload(p, 0);
		// length one past the maximum; trailing byte ignored
		p = {8'h01, 8'h80, 8'h01, 8'h00, 8'h00, 8'h55};
		send_payload(p, 0);
		// skip one byte, end with a byteless last item
		p = {8'h05, 8'h40, 8'h01, 8'hFF};
		send_payload(p, 1);

		// stall the result side so last-byte transfers back up the input
		hold_req = 1;
		repeat (12) begin
			p = {8'($urandom)};
			send_payload(p, 0);
		end
		drain_results();

		// maximum option length: accept it, end the payload while skipping
		p = {8'h01, 8'h80, 8'h00, 8'hFF, 8'hFF};
		repeat (20)
			p.push_back(8'($urandom));
		send_payload(p, 0);
		drain_results();

		n_sent = 0;
		while (n_sent < 1200) begin
			if (n_sent > 1050)
				calm = 1;
			build_payload(p, te);
			send_payload(p, te);
		end
		drain_results();
		repeat (8) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS setup_option_list_checker_unit");
		else
			$display("FAIL setup_option_list_checker_unit");
		$finish;
	end

endmodule
